/* rtl/cprm_pkg.sv */
// Package for the chunk peak and RMS level meter.
// Holds field widths, scaling constants and the sequencer state type.
// No dependencies.
package cprm_pkg;

  localparam int DEF_MAX_CHUNK_SAMPLES = 4096;

  localparam int SAMPLE_W  = 16;
  localparam int INDEX_W   = 32;
  localparam int LEVEL_W   = 14;
  localparam int ROOT_W    = 14;
  // A squared magnitude is at most 2^30, which needs 31 bits.
  localparam int SQ_W      = 31;

  localparam int LEVEL_SCALE = 10000;
  localparam int PEAK_SHIFT  = 15;

  // 10^8 / 2^30 = 390625 / 2^22; the sum of squares is scaled in two halves.
  localparam int RMS_T_MUL   = 390625;
  localparam int RMS_MUL_W   = 19;
  localparam int T_SHIFT     = 22;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_ACC,
    ST_PEAK,
    ST_THI,
    ST_TLO,
    ST_TADD,
    ST_TRY_SQ,
    ST_TRY_N,
    ST_TRY_CMP,
    ST_DONE
  } state_e;

endpackage

/* rtl/chunk_peak_rms_meter.sv */
// Chunk peak and RMS level meter: one sample per transaction, one result per chunk.
// Input: a sample without the end flag is squared and accumulated before the next is taken;
// after a flagged one the input reopens once the result is loaded, later while an earlier result is held.
// Result: a flagged sample's result is loaded once the 14-step square-root search ends;
// each step is a square, a scale by the count and a compare.
// Reset (rst_ni, asynchronous, active low) clears the accumulators, chunk index and out valid.
module chunk_peak_rms_meter
  import cprm_pkg::*;
#(
  parameter int MAX_CHUNK_SAMPLES = DEF_MAX_CHUNK_SAMPLES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic                last_of_chunk_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [INDEX_W-1:0]  chunk_index_o,
  output logic [LEVEL_W-1:0]  peak_level_o,
  output logic [LEVEL_W-1:0]  rms_level_o
);

  localparam int CNT_W  = $clog2(MAX_CHUNK_SAMPLES + 1);
  localparam int SUM_W  = SQ_W + $clog2(MAX_CHUNK_SAMPLES);
  localparam int HI_W   = SUM_W - T_SHIFT;
  localparam int T_W    = HI_W + RMS_MUL_W + 1;
  localparam int MA_W0  = (2 * ROOT_W > HI_W) ? 2 * ROOT_W : HI_W;
  localparam int MA_W   = (MA_W0 > T_SHIFT) ? MA_W0 : T_SHIFT;
  localparam int MB_W0  = (RMS_MUL_W > CNT_W) ? RMS_MUL_W : CNT_W;
  localparam int MB_W   = (MB_W0 > SAMPLE_W) ? MB_W0 : SAMPLE_W;
  localparam int PROD_W = MA_W + MB_W;
  localparam int CMP_W  = (T_W > PROD_W) ? T_W : PROD_W;
  localparam int BIT_W  = $clog2(ROOT_W);

  state_e state_q, state_d;

  logic [SAMPLE_W-1:0] mag_q;
  logic                last_q;
  logic                en_q;
  logic [SAMPLE_W-1:0] peak_q;
  logic [SUM_W-1:0]    sum_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [INDEX_W-1:0]  chunk_q;
  logic [LEVEL_W-1:0]  peak_lvl_q;
  logic [T_W-1:0]      t_q;
  logic [ROOT_W-1:0]   root_q;
  logic [BIT_W-1:0]    bit_q;

  logic                out_valid_q;
  logic [INDEX_W-1:0]  out_index_q;
  logic [LEVEL_W-1:0]  out_peak_q;
  logic [LEVEL_W-1:0]  out_rms_q;

  logic [MA_W-1:0]     mul_a;
  logic [MB_W-1:0]     mul_b;
  logic [PROD_W-1:0]   prod;
  logic [ROOT_W-1:0]   trial;
  logic [SAMPLE_W-1:0] in_mag;
  logic                out_free;
  logic                out_load;

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == ST_DONE) && out_free;
  assign trial    = root_q | (ROOT_W'(1) << bit_q);
  // Negating the most negative sample wraps to 0x8000, which is its magnitude.
  assign in_mag   = sample_i[SAMPLE_W-1] ? (~sample_i + SAMPLE_W'(1)) : sample_i;

  cprm_mul #(
    .A_W(MA_W),
    .B_W(MB_W)
  ) u_mul (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    mul_a      = '0;
    mul_b      = '0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        mul_a   = MA_W'(mag_q);
        mul_b   = MB_W'(mag_q);
        state_d = ST_ACC;
      end
      ST_ACC: begin
        state_d = last_q ? ST_PEAK : ST_IDLE;
      end
      ST_PEAK: begin
        mul_a   = MA_W'(peak_q);
        mul_b   = MB_W'(LEVEL_SCALE);
        state_d = ST_THI;
      end
      ST_THI: begin
        mul_a   = MA_W'(sum_q[SUM_W-1:T_SHIFT]);
        mul_b   = MB_W'(RMS_T_MUL);
        state_d = ST_TLO;
      end
      ST_TLO: begin
        mul_a   = MA_W'(sum_q[T_SHIFT-1:0]);
        mul_b   = MB_W'(RMS_T_MUL);
        state_d = ST_TADD;
      end
      ST_TADD: begin
        state_d = ST_TRY_SQ;
      end
      ST_TRY_SQ: begin
        mul_a   = MA_W'(trial);
        mul_b   = MB_W'(trial);
        state_d = ST_TRY_N;
      end
      ST_TRY_N: begin
        mul_a   = MA_W'(prod[2*ROOT_W-1:0]);
        mul_b   = MB_W'(cnt_q);
        state_d = ST_TRY_CMP;
      end
      ST_TRY_CMP: begin
        state_d = (bit_q == '0) ? ST_DONE : ST_TRY_SQ;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Chunk accumulators and chunk index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q  <= '0;
      sum_q   <= '0;
      cnt_q   <= '0;
      chunk_q <= '0;
    end else if (state_q == ST_ACC && en_q) begin
      if (mag_q > peak_q) begin
        peak_q <= mag_q;
      end
      sum_q <= sum_q + SUM_W'(prod[SQ_W-1:0]);
      cnt_q <= cnt_q + CNT_W'(1);
    end else if (out_load) begin
      peak_q  <= '0;
      sum_q   <= '0;
      cnt_q   <= '0;
      chunk_q <= chunk_q + INDEX_W'(1);
    end
  end

  // Working registers of the current transaction and the square-root search.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        mag_q  <= in_mag;
        last_q <= last_of_chunk_i;
        en_q   <= cnt_q < CNT_W'(MAX_CHUNK_SAMPLES);
      end
      ST_THI: begin
        peak_lvl_q <= prod[PEAK_SHIFT+LEVEL_W-1:PEAK_SHIFT];
      end
      ST_TLO: begin
        t_q <= T_W'(prod);
      end
      ST_TADD: begin
        t_q    <= t_q + T_W'(prod >> T_SHIFT);
        root_q <= '0;
        bit_q  <= BIT_W'(ROOT_W - 1);
      end
      ST_TRY_CMP: begin
        // Keep the trial bit when trial^2 * count still fits under the scaled sum.
        if (CMP_W'(prod) <= CMP_W'(t_q)) begin
          root_q <= trial;
        end
        bit_q <= bit_q - BIT_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_index_q <= chunk_q;
      out_peak_q  <= peak_lvl_q;
      out_rms_q   <= (root_q > ROOT_W'(LEVEL_SCALE)) ? LEVEL_W'(LEVEL_SCALE)
                                                      : LEVEL_W'(root_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign chunk_index_o = out_index_q;
  assign peak_level_o  = out_peak_q;
  assign rms_level_o   = out_rms_q;

endmodule

/* rtl/cprm_mul.sv */
// Shared unsigned multiplier of the level meter, with a registered product.
// Operands are selected by the sequencer in the top level; no package use.
module cprm_mul #(
  parameter int A_W = 28,
  parameter int B_W = 19
) (
  input  logic                 clk_i,
  input  logic [A_W-1:0]       a_i,
  input  logic [B_W-1:0]       b_i,
  output logic [A_W+B_W-1:0]   p_o
);

  logic [A_W+B_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= (A_W+B_W)'(a_i) * (A_W+B_W)'(b_i);
  end

  assign p_o = prod_q;

endmodule

/* rtl/cprm_checker.sv */
// Port-level checker for the chunk peak and RMS level meter, bound to the top level.
// Depends on cprm_pkg for field widths and the level scale.
module cprm_checker
  import cprm_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                last_of_chunk_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [INDEX_W-1:0]  chunk_index_o,
  input logic [LEVEL_W-1:0]  peak_level_o,
  input logic [LEVEL_W-1:0]  rms_level_o
);

  // The meter squares and accumulates each sample before taking the next, so the input closes after each transaction.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted twice in consecutive cycles");

  // A sample without the end flag never produces a result.
  a_no_result_mid_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !last_of_chunk_i && !out_valid_o) |=> !out_valid_o)
    else $error("result appeared for a sample that does not end a chunk");

  // A result held off by the receiver stays offered and unchanged.
  a_out_held_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(chunk_index_o) &&
                                     $stable(peak_level_o) && $stable(rms_level_o))
    else $error("stalled result dropped or changed");

  a_levels_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (peak_level_o <= LEVEL_W'(LEVEL_SCALE)) &&
                    (rms_level_o <= LEVEL_W'(LEVEL_SCALE)))
    else $error("level above full scale");

  a_reset_clears_out: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind chunk_peak_rms_meter cprm_checker u_cprm_checker (.*);

/* bench/tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for chunk_peak_rms_meter: random and directed chunks of samples,
// results predicted in-bench and compared per field. Depends on cprm_pkg and the meter RTL.
module tb
  import cprm_pkg::*;
();

  localparam int CHUNK_CAP   = DEF_MAX_CHUNK_SAMPLES;
  localparam int RANDOM_ITEMS = 1550;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int TAIL_CYCLES = 80;

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
    bit                  drain_first;
  } sample_txn_t;

  typedef struct {
    logic [INDEX_W-1:0] index;
    logic [LEVEL_W-1:0] peak;
    logic [LEVEL_W-1:0] rms;
  } level_rec_t;

  logic                clk_i;
  logic                rst_ni          = 1'b0;
  logic                in_valid_i      = 1'b0;
  logic                in_stall_o;
  logic [SAMPLE_W-1:0] sample_i        = '0;
  logic                last_of_chunk_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i     = 1'b0;
  logic [INDEX_W-1:0]  chunk_index_o;
  logic [LEVEL_W-1:0]  peak_level_o;
  logic [LEVEL_W-1:0]  rms_level_o;

  chunk_peak_rms_meter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_i        (sample_i),
    .last_of_chunk_i (last_of_chunk_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .chunk_index_o   (chunk_index_o),
    .peak_level_o    (peak_level_o),
    .rms_level_o     (rms_level_o)
  );

  sample_txn_t samples_to_send[$];
  level_rec_t  due_levels[$];

  // Meter state as the bench sees it.
  int unsigned       peak_acc;
  longint unsigned   sq_acc;
  int unsigned       n_acc;
  logic [INDEX_W-1:0] chunk_no;

  int unsigned err_cnt;
  int unsigned sent_cnt;
  int unsigned levels_seen;
  int unsigned cycle_cnt;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned hold_left;
  int unsigned rand_items;
  logic        next_valid;
  logic        next_stall;
  level_rec_t  want;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Largest r in 0..10000 with r*r*n <= floor(s * 10^8 / 2^30); 10^8 / 2^30 = 390625 / 2^22.
  function automatic logic [LEVEL_W-1:0] rms_from(longint unsigned s, int unsigned n);
    longint unsigned scaled;
    int unsigned     lo;
    int unsigned     hi;
    int unsigned     mid;
    scaled = (s * 64'd390625) >> 22;
    lo = 0;
    hi = LEVEL_SCALE;
    if (n == 0) return '0;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (longint'(mid) * mid * n <= scaled) lo = mid;
      else hi = mid - 1;
    end
    return lo[LEVEL_W-1:0];
  endfunction

  task automatic meter_sample(input sample_txn_t s);
    int unsigned mag;
    level_rec_t  rec;
    mag = s.sample[SAMPLE_W-1] ? (32'h10000 - s.sample) : s.sample;
    if (n_acc < CHUNK_CAP) begin
      if (mag > peak_acc) peak_acc = mag;
      sq_acc += longint'(mag) * mag;
      n_acc++;
    end
    if (s.last) begin
      rec.index = chunk_no;
      rec.peak  = LEVEL_W'((peak_acc * LEVEL_SCALE) >> PEAK_SHIFT);
      rec.rms   = rms_from(sq_acc, n_acc);
      due_levels.push_back(rec);
      chunk_no++;
      peak_acc = 0;
      sq_acc   = 0;
      n_acc    = 0;
    end
  endtask

  task automatic add_sample(input logic [SAMPLE_W-1:0] s, input logic last, input bit drain);
    sample_txn_t t;
    t.sample      = s;
    t.last        = last;
    t.drain_first = drain;
    samples_to_send.push_back(t);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    logic [SAMPLE_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = 16'h8000;
      1: v = 16'h7FFF;
      2: v = 16'h0000;
      3, 4: begin
        v = SAMPLE_W'($urandom_range(0, 255));
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = SAMPLE_W'($urandom);
    endcase
    return v;
  endfunction

  // Most gaps are short, a few long; every fourth stretch of 200 has none at all.
  function automatic int unsigned pick_gap(int unsigned phase_cnt);
    int unsigned r;
    r = $urandom_range(0, 99);
    if ((phase_cnt / 200) % 4 == 1) return 0;
    if (r < 58) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic check_field(input string name, input longint unsigned exp_v,
                             input longint unsigned got_v);
    if (exp_v != got_v) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
    end
  endtask

  initial begin
    int unsigned len;
    peak_acc  = 0;
    sq_acc    = 0;
    n_acc     = 0;
    chunk_no  = '0;
    err_cnt   = 0;

    // One-sample chunks at the extremes, including the most negative sample.
    add_sample(16'h8000, 1'b1, 0);
    add_sample(16'h7FFF, 1'b1, 0);
    add_sample(16'h0000, 1'b1, 0);
    add_sample(16'h0001, 1'b1, 0);
    add_sample(16'hFFFF, 1'b1, 0);
    // Mixed short chunks.
    add_sample(16'h8000, 1'b0, 0);
    add_sample(16'h7FFF, 1'b0, 0);
    add_sample(16'h0001, 1'b0, 0);
    add_sample(16'h0000, 1'b1, 0);
    add_sample(16'h0100, 1'b0, 0);
    add_sample(16'hFF00, 1'b0, 0);
    add_sample(16'h4000, 1'b0, 0);
    add_sample(16'hC000, 1'b1, 0);
    for (int i = 0; i < 4; i++) add_sample(16'h8000, i == 3, 0);
    add_sample(16'h5555, 1'b0, 0);
    add_sample(16'hAAAA, 1'b1, 0);

    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
      for (int i = 0; i < len; i++) begin
        add_sample(pick_sample(), i == len - 1, rand_items == 0);
        rand_items++;
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (samples_to_send.size() != 0 || due_levels.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && due_levels.size() == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

  // Sample driver. A transaction flagged drain_first waits until every result is in.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      next_valid = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        meter_sample(samples_to_send.pop_front());
        sent_cnt++;
        gap_left   = pick_gap(sent_cnt);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (samples_to_send.size() != 0 &&
                     !(samples_to_send[0].drain_first && due_levels.size() != 0)) begin
          next_valid = 1'b1;
          sample_i        <= samples_to_send[0].sample;
          last_of_chunk_i <= samples_to_send[0].last;
        end
      end
      in_valid_i <= next_valid;
    end
  end

  // Result monitor and receiver stall.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (due_levels.size() == 0) begin
          err_cnt++;
          $display("%0t: result with none expected, actual index %0d peak %0d rms %0d",
                   $time, chunk_index_o, peak_level_o, rms_level_o);
        end else begin
          want = due_levels.pop_front();
          check_field("chunk_index", want.index, chunk_index_o);
          check_field("peak_level", want.peak, peak_level_o);
          check_field("rms_level", want.rms, rms_level_o);
        end
        levels_seen++;
        // A long hold-off lets the meter fill up and push back on the sample side.
        if (levels_seen == 40) hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_stall = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        next_stall = 1'b1;
      end else begin
        stall_left = pick_gap(levels_seen * 10 + 400);
        next_stall = (stall_left != 0);
        if (next_stall) stall_left--;
      end
      out_stall_i <= next_stall;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

endmodule

/* chunk_peak_rms_meter.f */
rtl/cprm_pkg.sv
rtl/cprm_mul.sv
rtl/chunk_peak_rms_meter.sv
rtl/cprm_checker.sv
bench/tb.sv
